FILE: rtl/core/systick_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_pkg: shared types and constants
// Item kinds, register offsets, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package systick_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 24;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  localparam logic [7:0] OFS_CONTROL = 8'h00;
  localparam logic [7:0] OFS_RELOAD  = 8'h04;
  localparam logic [7:0] OFS_CURRENT = 8'h08;
  localparam logic [7:0] OFS_CALIB   = 8'h0C;

  localparam int unsigned CTRL_ENABLE = 0;
  localparam int unsigned CTRL_INT    = 1;
  localparam int unsigned FLAG_POS    = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;        // capture the accepted item
    logic commit;      // finish a one-step item
    logic div_start;   // start the remainder unit
    logic div_step;    // one remainder iteration
    logic div_commit;  // finish an expiring tick
  } cmd_t;

  typedef struct packed {
    logic expire;      // held item is a tick that reaches expiry
    logic div_last;    // final remainder iteration this cycle
    logic slot_free;   // result register can take a new result
  } sts_t;

endpackage

FILE: rtl/core/systick_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_if: item and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface systick_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  offset;
  logic [31:0] write_data;
  logic [31:0] elapsed;

  modport source (output valid, output kind, output offset, output write_data,
                  output elapsed, input ready);
  modport sink   (input valid, input kind, input offset, input write_data,
                  input elapsed, output ready);
endinterface

interface systick_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        fired;
  logic        pending_out;

  modport source (output valid, output read_data, output fired,
                  output pending_out, input ready);
  modport sink   (input valid, input read_data, input fired,
                  input pending_out, output ready);
endinterface

FILE: rtl/core/systick_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_ctrl: item sequencer
// Capture and execute; an expiring tick adds remainder iterations and finish.
// ----------------------------------------------------------------------------
module systick_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  systick_pkg::sts_t  sts,
  output systick_pkg::cmd_t  cmd
);

  systick_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= systick_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      systick_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = systick_pkg::ST_EXEC;
      end
      systick_pkg::ST_EXEC: begin
        if (sts.expire) state_nxt = systick_pkg::ST_DIV;
        else if (sts.slot_free) state_nxt = systick_pkg::ST_IDLE;
      end
      systick_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = systick_pkg::ST_FIN;
      end
      systick_pkg::ST_FIN: begin
        if (sts.slot_free) state_nxt = systick_pkg::ST_IDLE;
      end
      default: state_nxt = systick_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      systick_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      systick_pkg::ST_EXEC: begin
        cmd.div_start = sts.expire;
        cmd.commit    = !sts.expire && sts.slot_free;
      end
      systick_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      systick_pkg::ST_FIN: begin
        cmd.div_commit = sts.slot_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/systick_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_dp: timer registers, remainder unit and result register
// Holds the bus registers and the counter, a restoring remainder unit one
// dividend bit per cycle, and the result register toward the output channel.
// ----------------------------------------------------------------------------
module systick_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  systick_pkg::cmd_t  cmd,
  output systick_pkg::sts_t  sts,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_offset,
  input  logic [31:0]        in_write_data,
  input  logic [31:0]        in_elapsed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_read_data,
  output logic               out_fired,
  output logic               out_pending_out
);

  localparam int unsigned CW = systick_pkg::CNT_W;
  localparam int unsigned DW = systick_pkg::DATA_W;
  localparam int unsigned SW = systick_pkg::STEP_W;

  // Timer state
  logic [2:0]    ctrl_r,   ctrl_nxt;
  logic          flag_r,   flag_nxt;
  logic [CW-1:0] reload_r, reload_nxt;
  logic [CW:0]   cur_r,    cur_nxt;
  logic          pend_r,   pend_nxt;

  // Held item
  logic [1:0]    kind_r;
  logic [7:0]    ofs_r;
  logic [DW-1:0] wdata_r;
  logic [DW-1:0] elap_r;

  // Remainder unit
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] step_r, step_nxt;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] rd_r, rd_nxt;
  logic          fired_r, fired_nxt;
  logic          pendo_r, pendo_nxt;

  logic [CW:0]   period;
  logic [CW:0]   cur_eff;
  logic          tick_on;
  logic          expire;
  logic [DW-1:0] left;
  logic [CW:0]   trial;

  assign period  = {1'b0, reload_r} + {{CW{1'b0}}, 1'b1};
  assign cur_eff = (cur_r == '0) ? period : cur_r;
  assign tick_on = ctrl_r[systick_pkg::CTRL_ENABLE] && (reload_r != '0);
  assign expire  = (kind_r == systick_pkg::KIND_TICK) && tick_on &&
                   ({{(DW-CW-1){1'b0}}, cur_eff} <= elap_r);
  assign left    = elap_r - {{(DW-CW-1){1'b0}}, cur_eff};
  assign trial   = {rem_r, dvd_r[DW-1]};

  assign sts.expire    = expire;
  assign sts.div_last  = (step_r == SW'(systick_pkg::DIV_STEPS - 1));
  assign sts.slot_free = !out_valid_r || out_ready;

  // Remainder iterations
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (cmd.div_start) begin
      dvd_nxt  = left;
      rem_nxt  = '0;
      step_nxt = '0;
    end else if (cmd.div_step) begin
      dvd_nxt  = {dvd_r[DW-2:0], 1'b0};
      step_nxt = step_r + SW'(1);
      // remainder stays below the period, so it fits the counter width
      if (trial >= period) rem_nxt = CW'(trial - period);
      else rem_nxt = trial[CW-1:0];
    end
  end

  // Register updates and result
  always_comb begin
    ctrl_nxt      = ctrl_r;
    flag_nxt      = flag_r;
    reload_nxt    = reload_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    rd_nxt        = rd_r;
    fired_nxt     = fired_r;
    pendo_nxt     = pendo_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      rd_nxt        = '0;
      fired_nxt     = 1'b0;
      pendo_nxt     = 1'b0;
      case (kind_r)
        systick_pkg::KIND_READ: begin
          unique case (ofs_r)
            systick_pkg::OFS_CONTROL: begin
              rd_nxt[2:0]                  = ctrl_r;
              rd_nxt[systick_pkg::FLAG_POS] = flag_r;
              flag_nxt                     = 1'b0;
            end
            systick_pkg::OFS_RELOAD:  rd_nxt = {{(DW-CW){1'b0}}, reload_r};
            systick_pkg::OFS_CURRENT: rd_nxt = {{(DW-CW){1'b0}}, cur_r[CW-1:0]};
            default:                  rd_nxt = '0;
          endcase
        end
        systick_pkg::KIND_WRITE: begin
          unique case (ofs_r)
            systick_pkg::OFS_CONTROL: ctrl_nxt   = wdata_r[2:0];
            systick_pkg::OFS_RELOAD:  reload_nxt = wdata_r[CW-1:0];
            systick_pkg::OFS_CURRENT: begin
              cur_nxt  = '0;
              flag_nxt = 1'b0;
            end
            default: ;
          endcase
        end
        systick_pkg::KIND_TICK: begin
          // elapsed is below the loaded count here, so the count stays nonzero
          if (tick_on) cur_nxt = cur_eff - elap_r[CW:0];
        end
        default: begin
          pendo_nxt = pend_r;
          pend_nxt  = 1'b0;
        end
      endcase
    end else if (cmd.div_commit) begin
      out_valid_nxt = 1'b1;
      rd_nxt        = '0;
      pendo_nxt     = 1'b0;
      cur_nxt       = period - {1'b0, rem_r};
      flag_nxt      = 1'b1;
      fired_nxt     = ctrl_r[systick_pkg::CTRL_INT];
      if (ctrl_r[systick_pkg::CTRL_INT]) pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      flag_r      <= 1'b0;
      reload_r    <= '0;
      cur_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      ctrl_r      <= ctrl_nxt;
      flag_r      <= flag_nxt;
      reload_r    <= reload_nxt;
      cur_r       <= cur_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      ofs_r   <= in_offset;
      wdata_r <= in_write_data;
      elap_r  <= in_elapsed;
    end
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    rd_r    <= rd_nxt;
    fired_r <= fired_nxt;
    pendo_r <= pendo_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = rd_r;
  assign out_fired       = fired_r;
  assign out_pending_out = pendo_r;

endmodule

FILE: rtl/core/systick_reload_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_reload_timer: 24-bit down-counting reload timer
// Bus reads and writes, elapsed-count ticks and pending queries, one result
// per item.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Reads, writes, pending queries and ticks
// that do not reach expiry finish in the execute step. A tick that passes
// expiry runs the leftover count through a restoring remainder unit that
// retires one dividend bit per cycle, then finishes in its own step. A result
// waiting in the output register does not block the transfer of the next
// item; that item finishes once the result has been taken.
module systick_reload_timer (
  input  logic          clk,
  input  logic          rst_n,
  systick_in_if.sink    in_ch,
  systick_out_if.source out_ch
);

  systick_pkg::cmd_t cmd;
  systick_pkg::sts_t sts;

  systick_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  systick_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_ch.kind),
    .in_offset       (in_ch.offset),
    .in_write_data   (in_ch.write_data),
    .in_elapsed      (in_ch.elapsed),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_read_data   (out_ch.read_data),
    .out_fired       (out_ch.fired),
    .out_pending_out (out_ch.pending_out)
  );

endmodule

FILE: rtl/core/systick_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_chk: port-level checks
// Result channel handshake and consistency of the result fields.
// ----------------------------------------------------------------------------
module systick_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_fired,
  input logic        out_pending_out
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_fired_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> (out_read_data == 32'd0) && !out_pending_out)
    else $error("fired result carries other fields");

  a_pend_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pending_out |-> (out_read_data == 32'd0))
    else $error("pending result carries read data");

  a_read_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_data[31:24] == 8'd0))
    else $error("read data beyond 24 bits");

  // hold the payload while the result waits
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_data) && $stable(out_fired) &&
                                $stable(out_pending_out))
    else $error("result changed before transfer");

endmodule

bind systick_reload_timer systick_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_read_data   (out_ch.read_data),
  .out_fired       (out_ch.fired),
  .out_pending_out (out_ch.pending_out)
);

FILE: test/systick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// systick_result_checker: result predictor and scoreboard
// Watches both channels of the reload timer. Every item transfer updates a
// local copy of the timer state and queues the result it should produce;
// every result transfer is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module systick_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  systick_in_if       in_ch,
  systick_out_if      out_ch,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [31:0] read_data;
    logic        fired;
    logic        pending_out;
  } timer_result_t;

  logic [2:0]  ctrl_bits;
  logic        count_flag;
  logic [23:0] reload_val;
  logic [24:0] current_val;
  logic        pending_mark;

  timer_result_t expected_results[$];

  function automatic timer_result_t predict_timer_result(logic [1:0] kind,
                                                         logic [7:0] ofs,
                                                         logic [31:0] wdata,
                                                         logic [31:0] elapsed);
    timer_result_t res;
    logic [24:0]   period;
    logic [31:0]   leftover;
    logic [31:0]   rem;
    res = '0;
    case (kind)
      systick_pkg::KIND_READ: begin
        case (ofs)
          systick_pkg::OFS_CONTROL: begin
            res.read_data[2:0]                   = ctrl_bits;
            res.read_data[systick_pkg::FLAG_POS] = count_flag;
            count_flag                           = 1'b0;
          end
          systick_pkg::OFS_RELOAD:  res.read_data = {8'd0, reload_val};
          systick_pkg::OFS_CURRENT: res.read_data = {8'd0, current_val[23:0]};
          default: ;
        endcase
      end
      systick_pkg::KIND_WRITE: begin
        case (ofs)
          systick_pkg::OFS_CONTROL: ctrl_bits = wdata[2:0];
          systick_pkg::OFS_RELOAD:  reload_val = wdata[23:0];
          systick_pkg::OFS_CURRENT: begin
            current_val = '0;
            count_flag  = 1'b0;
          end
          default: ;
        endcase
      end
      systick_pkg::KIND_TICK: begin
        if (ctrl_bits[systick_pkg::CTRL_ENABLE] && reload_val != '0) begin
          period = {1'b0, reload_val} + 25'd1;
          if (current_val == '0) current_val = period;
          if (elapsed >= {7'd0, current_val}) begin
            // wrap the leftover counts into the period
            leftover    = elapsed - {7'd0, current_val};
            rem         = leftover % {7'd0, period};
            current_val = period - rem[24:0];
            count_flag  = 1'b1;
            if (ctrl_bits[systick_pkg::CTRL_INT]) begin
              pending_mark = 1'b1;
              res.fired    = 1'b1;
            end
          end else begin
            current_val = current_val - elapsed[24:0];
          end
        end
      end
      default: begin
        res.pending_out = pending_mark;
        pending_mark    = 1'b0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    timer_result_t exp_res;
    if (!rst_n) begin
      ctrl_bits    = '0;
      count_flag   = 1'b0;
      reload_val   = '0;
      current_val  = '0;
      pending_mark = 1'b0;
      expected_results.delete();
      fail_count   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_timer_result(in_ch.kind, in_ch.offset,
                                                        in_ch.write_data,
                                                        in_ch.elapsed));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer: read_data %h fired %b pending %b",
                   $time, out_ch.read_data, out_ch.fired, out_ch.pending_out);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.read_data !== exp_res.read_data) begin
            $display("%0t: read_data mismatch: expected %h actual %h",
                     $time, exp_res.read_data, out_ch.read_data);
            fail_count++;
          end
          if (out_ch.fired !== exp_res.fired) begin
            $display("%0t: fired mismatch: expected %b actual %b",
                     $time, exp_res.fired, out_ch.fired);
            fail_count++;
          end
          if (out_ch.pending_out !== exp_res.pending_out) begin
            $display("%0t: pending_out mismatch: expected %b actual %b",
                     $time, exp_res.pending_out, out_ch.pending_out);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: reload timer testbench
// Runs a directed sequence over register edges, expiry and pending handling,
// then three random phases with varying backpressure, including two long
// receiver hold-offs. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned HOLD_OFF_LEN   = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned ITEMS_PER_PASS = 600;

  logic clk;
  logic rst_n;

  systick_in_if  in_ch();
  systick_out_if out_ch();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned reload_shadow;
  bit          hold_off_req;

  systick_reload_timer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  systick_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL systick_reload_timer");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  task automatic offer_item(logic [1:0] kind, logic [7:0] ofs,
                            logic [31:0] data, logic [31:0] elapsed);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.offset     <= ofs;
    in_ch.write_data <= data;
    in_ch.elapsed    <= elapsed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic bus_read(logic [7:0] ofs);
    offer_item(systick_pkg::KIND_READ, ofs, $urandom, $urandom);
  endtask

  task automatic bus_write(logic [7:0] ofs, logic [31:0] data);
    if (ofs == systick_pkg::OFS_RELOAD) reload_shadow = {8'd0, data[23:0]};
    offer_item(systick_pkg::KIND_WRITE, ofs, data, $urandom);
  endtask

  task automatic tick(logic [31:0] elapsed);
    offer_item(systick_pkg::KIND_TICK, 8'($urandom), $urandom, elapsed);
  endtask

  task automatic query_pending();
    offer_item(systick_pkg::KIND_QUERY, 8'($urandom), $urandom, $urandom);
  endtask

  function automatic logic [7:0] pick_offset();
    case ($urandom_range(19))
      0, 1, 2, 3, 4: return systick_pkg::OFS_CONTROL;
      5, 6, 7, 8:    return systick_pkg::OFS_RELOAD;
      9, 10, 11, 12: return systick_pkg::OFS_CURRENT;
      13, 14, 15:    return systick_pkg::OFS_CALIB;
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_pass(int unsigned n);
    int unsigned roll;
    logic [7:0]  ofs;
    logic [31:0] data;
    logic [31:0] elapsed;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        case ($urandom_range(9))
          0:       elapsed = $urandom;
          1:       elapsed = '0;
          default: elapsed = $urandom_range(2 * reload_shadow + 2);
        endcase
        tick(elapsed);
      end else if (roll < 65) begin
        bus_read(pick_offset());
      end else if (roll < 85) begin
        ofs  = pick_offset();
        data = $urandom;
        if (ofs == systick_pkg::OFS_CONTROL) begin
          // keep the counter running most of the time
          data[systick_pkg::CTRL_ENABLE] = ($urandom_range(9) != 0);
        end else if (ofs == systick_pkg::OFS_RELOAD) begin
          case ($urandom_range(9))
            0:       data[23:0] = '0;
            1:       data[23:0] = 24'hFFFFFF;
            2, 3:    ;
            default: data[23:0] = 24'($urandom_range(40));
          endcase
        end
        bus_write(ofs, data);
      end else begin
        query_pending();
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= systick_pkg::KIND_READ;
    in_ch.offset     <= '0;
    in_ch.write_data <= '0;
    in_ch.elapsed    <= '0;
    hold_off_req     = 1'b0;
    reload_shadow    = 0;
    src_idle_pct     = 15;
    dst_idle_pct     = 84;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, odd offsets, masking, expiry and pending
    bus_read(systick_pkg::OFS_CONTROL);
    bus_read(systick_pkg::OFS_RELOAD);
    bus_read(systick_pkg::OFS_CURRENT);
    bus_read(systick_pkg::OFS_CALIB);
    bus_read(8'hFF);
    query_pending();
    tick(32'hFFFFFFFF);
    bus_write(systick_pkg::OFS_RELOAD, 32'hFFFFFFFF);
    bus_read(systick_pkg::OFS_RELOAD);
    bus_write(systick_pkg::OFS_CONTROL, 32'hFFFFFFFF);
    tick(32'd0);
    bus_read(systick_pkg::OFS_CURRENT);
    tick(32'hFFFFFFFF);
    query_pending();
    query_pending();
    bus_read(systick_pkg::OFS_CONTROL);
    bus_read(systick_pkg::OFS_CONTROL);
    bus_write(systick_pkg::OFS_CURRENT, $urandom);
    bus_read(systick_pkg::OFS_CURRENT);
    bus_write(systick_pkg::OFS_CALIB, 32'hFFFFFFFF);
    bus_write(8'h10, 32'hFFFFFFFF);
    bus_write(systick_pkg::OFS_RELOAD, 32'd0);
    tick(32'd5);
    bus_write(systick_pkg::OFS_RELOAD, 32'd1);
    tick(32'd1);
    tick(32'd1);
    bus_write(systick_pkg::OFS_CONTROL, 32'd1);
    tick(32'hFFFFFFFF);
    bus_read(systick_pkg::OFS_CONTROL);

    // hold the receiver so the block fills and stalls its input
    hold_off_req = 1'b1;
    random_pass(ITEMS_PER_PASS);

    src_idle_pct = 84;
    dst_idle_pct = 15;
    random_pass(ITEMS_PER_PASS);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_off_req = 1'b1;
    random_pass(ITEMS_PER_PASS);

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("PASS systick_reload_timer");
    else
      $display("FAIL systick_reload_timer");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/systick_pkg.sv
rtl/core/systick_if.sv
rtl/core/systick_ctrl.sv
rtl/core/systick_dp.sv
rtl/core/systick_reload_timer.sv
rtl/core/systick_chk.sv
test/systick_checker.sv
test/tb_top.sv
